// ===== src/ebhe_pkg.sv =====
`timescale 1ns / 1ps

package ebhe_pkg;

    localparam int BUF_BYTES = 13;
    localparam int BUF_W     = BUF_BYTES * 8;
    localparam int LEN_W     = 4;
    localparam int FIFO_DEPTH = 2;

    typedef struct packed {
        logic [BUF_W-1:0] data;
        logic [LEN_W-1:0] len;
    } t_entry;

endpackage

// ===== src/ebhe_front.sv =====
`timescale 1ns / 1ps

module ebhe_front (
    input  logic                 i_action,
    input  logic [31:0]          i_element_id,
    input  logic [55:0]          i_payload_size,
    input  logic [63:0]          i_uint_value,
    output ebhe_pkg::t_entry     o_entry
);
    import ebhe_pkg::*;

    function automatic logic [7:0] mark_byte(input logic [7:0] b, input logic [3:0] n);
        logic [7:0] mark;
        mark = 8'h80 >> (n - 4'd1);
        return (b & (mark - 8'd1)) | mark;
    endfunction

    logic [2:0]       id_n;
    logic [31:0]      id_left;
    logic [31:0]      hdr;
    logic [3:0]       vint_n;
    logic [63:0]      vint_left;
    logic [3:0]       uint_n;
    logic [63:0]      val_left;
    logic [71:0]      tail;
    logic [3:0]       tail_n;
    logic [BUF_W-1:0] tail_wide;

    always_comb begin
        priority if (i_element_id[31:24] != 8'd0) begin
            id_n = 3'd4;
        end else if (i_element_id[23:16] != 8'd0) begin
            id_n = 3'd3;
        end else if (i_element_id[15:8] != 8'd0) begin
            id_n = 3'd2;
        end else begin
            id_n = 3'd1;
        end
        id_left = i_element_id << {(3'd4 - id_n), 3'b000};
        hdr = {mark_byte(id_left[31:24], {1'b0, id_n}), id_left[23:0]};
    end

    always_comb begin
        vint_n = 4'd8;
        for (int i = 7; i >= 1; i--) begin
            if (i_payload_size < ((56'd1 << (7 * i)) - 56'd1)) begin
                vint_n = 4'(i);
            end
        end
        vint_left = {8'd0, i_payload_size} << {(4'd8 - vint_n), 3'b000};
        vint_left[63:56] = mark_byte(vint_left[63:56], vint_n);
    end

    always_comb begin
        uint_n = 4'd1;
        for (int i = 2; i <= 8; i++) begin
            if ((i_uint_value >> (8 * (i - 1))) != 64'd0) begin
                uint_n = 4'(i);
            end
        end
        val_left = i_uint_value << {(4'd8 - uint_n), 3'b000};
    end

    always_comb begin
        if (i_action) begin
            tail   = {8'h80 | {4'd0, uint_n}, val_left};
            tail_n = uint_n + 4'd1;
        end else begin
            tail   = {vint_left, 8'd0};
            tail_n = vint_n;
        end
        tail_wide    = {tail, 32'd0} >> {id_n, 3'b000};
        o_entry.data = {hdr, 72'd0} | tail_wide;
        o_entry.len  = {1'b0, id_n} + tail_n;
    end

endmodule

// ===== src/ebhe_fifo.sv =====
`timescale 1ns / 1ps

module ebhe_fifo (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push,
    input  ebhe_pkg::t_entry  i_entry,
    output logic              o_full,
    input  logic              i_pop,
    output logic              o_valid,
    output ebhe_pkg::t_entry  o_entry
);
    import ebhe_pkg::*;

    t_entry     r_mem [FIFO_DEPTH];
    logic       r_wr;
    logic       r_rd;
    logic [1:0] r_cnt;
    logic       n_wr;
    logic       n_rd;
    logic [1:0] n_cnt;
    logic       do_push;
    logic       do_pop;

    assign o_full  = (r_cnt == 2'(FIFO_DEPTH));
    assign o_valid = (r_cnt != 2'd0);
    assign o_entry = r_mem[r_rd];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && o_valid;

    always_comb begin
        n_wr  = do_push ? ~r_wr : r_wr;
        n_rd  = do_pop ? ~r_rd : r_rd;
        n_cnt = r_cnt + {1'b0, do_push} - {1'b0, do_pop};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= 1'b0;
            r_rd  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            r_wr  <= n_wr;
            r_rd  <= n_rd;
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr] <= i_entry;
        end
    end

endmodule

// ===== src/ebhe_back.sv =====
`timescale 1ns / 1ps

module ebhe_back (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_q_valid,
    input  ebhe_pkg::t_entry  i_q_entry,
    output logic              o_q_pop,
    output logic              o_valid,
    input  logic              i_stall,
    output logic [7:0]        o_out_byte,
    output logic              o_last
);
    import ebhe_pkg::*;

    logic [BUF_W-1:0] r_buf;
    logic [BUF_W-1:0] n_buf;
    logic [LEN_W-1:0] r_cnt;
    logic [LEN_W-1:0] n_cnt;
    logic             r_valid;
    logic             n_valid;
    logic [7:0]       r_byte;
    logic             r_last;
    logic             out_ready;
    logic             take;
    logic             need_load;

    always_comb begin
        out_ready = !r_valid || !i_stall;
        take      = out_ready && (r_cnt != '0);
        need_load = (r_cnt == '0) || (take && (r_cnt == LEN_W'(1)));
        o_q_pop   = need_load && i_q_valid;

        n_buf = r_buf;
        n_cnt = r_cnt;
        if (o_q_pop) begin
            n_buf = i_q_entry.data;
            n_cnt = i_q_entry.len;
        end else if (take) begin
            n_buf = r_buf << 8;
            n_cnt = r_cnt - LEN_W'(1);
        end
        n_valid = take ? 1'b1 : (out_ready ? 1'b0 : r_valid);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt   <= '0;
            r_valid <= 1'b0;
        end else begin
            r_cnt   <= n_cnt;
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_buf <= n_buf;
        if (take) begin
            r_byte <= r_buf[BUF_W-1 -: 8];
            r_last <= (r_cnt == LEN_W'(1));
        end
    end

    assign o_valid    = r_valid;
    assign o_out_byte = r_byte;
    assign o_last     = r_last;

endmodule

// ===== src/ebml_element_header_encoder_core.sv =====
`timescale 1ns / 1ps

// Encodes one EBML element per input item and sends it out one byte per cycle
// while i_stall is low and bytes wait, most significant first, with o_last on
// the final byte. An item yields 2 to 13 bytes; the output byte register sets
// the rate. Items are packed into a byte buffer in the cycle they are accepted
// and wait in a two-entry queue, so input is taken every cycle until that queue
// is full. When the block is idle, the first byte of an item passes through the
// queue entry, the shift buffer and the output byte register in that order.
module ebml_element_header_encoder_core (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic        i_action,
    input  logic [31:0] i_element_id,
    input  logic [55:0] i_payload_size,
    input  logic [63:0] i_uint_value,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [7:0]  o_out_byte,
    output logic        o_last
);
    import ebhe_pkg::*;

    t_entry front_entry;
    t_entry q_entry;
    logic   q_full;
    logic   q_valid;
    logic   q_pop;

    ebhe_front u_front (
        .i_action       (i_action),
        .i_element_id   (i_element_id),
        .i_payload_size (i_payload_size),
        .i_uint_value   (i_uint_value),
        .o_entry        (front_entry)
    );

    ebhe_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (i_valid),
        .i_entry (front_entry),
        .o_full  (q_full),
        .i_pop   (q_pop),
        .o_valid (q_valid),
        .o_entry (q_entry)
    );

    ebhe_back u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_q_valid  (q_valid),
        .i_q_entry  (q_entry),
        .o_q_pop    (q_pop),
        .o_valid    (o_valid),
        .i_stall    (i_stall),
        .o_out_byte (o_out_byte),
        .o_last     (o_last)
    );

    assign o_stall = q_full;

endmodule
